// ===== design/rgb_to_hsv_converter_defines.svh =====
// ---------------------------------------------------------------------------
// rgb_to_hsv_converter assertion macros
// Concurrent assertion helpers, clocked on clock and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define RTHC_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rthc implication check failed");
// antecedent implies consequent a fixed number of cycles later
`define RTHC_ASSERT_DELAY(label, ante, n, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error("rthc latency check failed");
// expression must never hold
`define RTHC_ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("rthc forbidden condition seen");
`else
`define RTHC_ASSERT_IMPL(label, ante, cons)
`define RTHC_ASSERT_DELAY(label, ante, n, cons)
`define RTHC_ASSERT_NEVER(label, expr)
`endif

`endif

// ===== design/rthc_pkg.sv =====
// ---------------------------------------------------------------------------
// rthc_pkg
// Shared types and constants of the RGB to HSV converter pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rthc_pkg;

   // one quotient bit per cell, quotients fit 17 bits
   localparam int DIV_STEPS   = 17;
   localparam int PIPE_LATENCY = DIV_STEPS + 2;

   localparam logic [13:0] GREEN_OFFSET = 14'd1920;
   localparam logic [13:0] BLUE_OFFSET  = 14'd3840;
   localparam logic [13:0] HUE_FULL     = 14'd5760;

   typedef enum logic [1:0] {
      SECTOR_RED,
      SECTOR_GREEN,
      SECTOR_BLUE
   } sector_type;

   // restoring divider lane: partial remainder and numerator/quotient shift
   typedef struct packed {
      logic [7:0]  rem;
      logic [16:0] nq;
   } div_lane_type;

   // word handed from cell to cell
   typedef struct packed {
      logic         valid;
      logic         grey;
      logic         negative;
      sector_type   sector;
      logic [7:0]   brightness;
      logic [7:0]   delta;
      div_lane_type sat;
      div_lane_type hue;
   } pipe_word_type;

endpackage

`default_nettype wire

// ===== design/rthc_front.sv =====
// ---------------------------------------------------------------------------
// rthc_front
// Finds max, min and hue sector of a pixel and loads both divider lanes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rthc_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   take,
   input  wire logic [7:0]             red,
   input  wire logic [7:0]             green,
   input  wire logic [7:0]             blue,
   output rthc_pkg::pipe_word_type     word_out
);
   import rthc_pkg::*;

   pipe_word_type word_in, word_ff;
   logic [7:0]    hi, lo, mag;
   logic [8:0]    diff;
   logic [17:0]   hue_num;
   sector_type    sector;

   // largest channel with ties going to red then green
   always_comb begin
      if (red >= green && red >= blue) begin
         sector = SECTOR_RED;
         hi     = red;
      end else if (green >= blue) begin
         sector = SECTOR_GREEN;
         hi     = green;
      end else begin
         sector = SECTOR_BLUE;
         hi     = blue;
      end
      lo = red;
      if (green < lo) lo = green;
      if (blue < lo) lo = blue;
   end

   // channel difference of the sector, as sign and magnitude
   always_comb begin
      case (sector)
         SECTOR_RED:   diff = {1'b0, green} - {1'b0, blue};
         SECTOR_GREEN: diff = {1'b0, blue} - {1'b0, red};
         SECTOR_BLUE:  diff = {1'b0, red} - {1'b0, green};
         default:      diff = 9'd0;
      endcase
      mag = diff[8] ? 8'(-diff) : diff[7:0];
      // 960 * mag as 1024 * mag - 64 * mag
      hue_num = {mag, 10'd0} - {4'd0, mag, 6'd0};
   end

   // load the lanes: numerator high part in the remainder, the rest shifts in
   always_comb begin
      word_in.valid      = take && !reset;
      word_in.grey       = (hi == lo);
      word_in.negative   = diff[8];
      word_in.sector     = sector;
      word_in.brightness = hi;
      word_in.delta      = hi - lo;
      word_in.sat.rem    = {1'b0, word_in.delta[7:1]};
      word_in.sat.nq     = {word_in.delta[0], 16'd0};
      word_in.hue.rem    = {7'd0, hue_num[17]};
      word_in.hue.nq     = hue_num[16:0];
   end

   // input register, valid bit cleared while in reset
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

`default_nettype wire

// ===== design/rthc_cell.sv =====
// ---------------------------------------------------------------------------
// rthc_cell
// One restoring division step on the saturation and hue lanes per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rthc_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  rthc_pkg::pipe_word_type     word_in_prev,
   output rthc_pkg::pipe_word_type     word_out
);
   import rthc_pkg::*;

   pipe_word_type word_in, word_ff;

   // shift one numerator bit into the remainder, subtract when it fits
   function automatic div_lane_type div_step(input div_lane_type lane,
                                             input logic [7:0] divisor);
      logic [8:0]   trial;
      logic         fits;
      div_lane_type res;
      trial   = {lane.rem, lane.nq[16]};
      fits    = (trial >= {1'b0, divisor});
      res.rem = fits ? 8'(trial - {1'b0, divisor}) : trial[7:0];
      res.nq  = {lane.nq[15:0], fits};
      return res;
   endfunction

   // side information passes through, both lanes take one step
   always_comb begin
      word_in       = word_in_prev;
      word_in.valid = word_in_prev.valid && !reset;
      word_in.sat   = div_step(word_in_prev.sat, word_in_prev.brightness);
      word_in.hue   = div_step(word_in_prev.hue, word_in_prev.delta);
   end

   // cell register, valid bit cleared while in reset
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

`default_nettype wire

// ===== design/rthc_back.sv =====
// ---------------------------------------------------------------------------
// rthc_back
// Applies sign, sector offset and wrap to the hue and registers the result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rthc_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  rthc_pkg::pipe_word_type     word_in_prev,
   output logic                        valid,
   output logic [12:0]                 hue_sixteenths,
   output logic [16:0]                 saturation_q16,
   output logic [7:0]                  brightness
);
   import rthc_pkg::*;

   logic        valid_in, valid_ff;
   logic [12:0] hue_in, hue_ff;
   logic [16:0] sat_in, sat_ff;
   logic [7:0]  bright_in, bright_ff;
   logic [13:0] offset, quotient, hue_raw;

   // sector offset plus signed quotient, wrapped into one turn
   always_comb begin
      case (word_in_prev.sector)
         SECTOR_RED:   offset = 14'd0;
         SECTOR_GREEN: offset = GREEN_OFFSET;
         SECTOR_BLUE:  offset = BLUE_OFFSET;
         default:      offset = 14'd0;
      endcase
      quotient = {4'd0, word_in_prev.hue.nq[9:0]};
      hue_raw  = word_in_prev.negative ? offset - quotient : offset + quotient;
      if (hue_raw[13]) begin
         hue_raw = hue_raw + HUE_FULL;
      end
   end

   // grey pixels give zero hue and saturation
   always_comb begin
      valid_in  = word_in_prev.valid;
      hue_in    = word_in_prev.grey ? 13'd0 : hue_raw[12:0];
      sat_in    = word_in_prev.grey ? 17'd0 : word_in_prev.sat.nq;
      bright_in = word_in_prev.brightness;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      hue_ff    <= hue_in;
      sat_ff    <= sat_in;
      bright_ff <= bright_in;
   end

   assign valid          = valid_ff;
   assign hue_sixteenths = hue_ff;
   assign saturation_q16 = sat_ff;
   assign brightness     = bright_ff;

endmodule

`default_nettype wire

// ===== design/rgb_to_hsv_converter.sv =====
// ---------------------------------------------------------------------------
// rgb_to_hsv_converter
// Pixel RGB to HSV conversion through a chain of restoring divider cells.
// ---------------------------------------------------------------------------
// Stages: front stage, 17 divider cells with one quotient bit each, and the
// output stage, all registered between start and rsp_valid.
// Throughput: one pixel per cycle; busy stays low, the receiver cannot stall.
// Reset: synchronous, clears the valid bits of all stages; data is not reset.
`timescale 1ns / 1ps
`default_nettype none

`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_red,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_blue,
   output logic             rsp_valid,
   output logic [12:0]      rsp_hue_sixteenths,
   output logic [16:0]      rsp_saturation_q16,
   output logic [7:0]       rsp_brightness
);
   import rthc_pkg::*;

   pipe_word_type chain [0:DIV_STEPS];
   logic          take;

   // a new transaction is taken every cycle
   assign busy = 1'b0;
   assign take = start && !busy;

   // max, min and lane loading
   rthc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .take     (take),
      .red      (req_red),
      .green    (req_green),
      .blue     (req_blue),
      .word_out (chain[0])
   );

   // divider cells, one quotient bit each
   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      rthc_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .word_in_prev (chain[i]),
         .word_out     (chain[i+1])
      );
   end

   // hue fix-up and output register
   rthc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .word_in_prev   (chain[DIV_STEPS]),
      .valid          (rsp_valid),
      .hue_sixteenths (rsp_hue_sixteenths),
      .saturation_q16 (rsp_saturation_q16),
      .brightness     (rsp_brightness)
   );

   // checks
   `RTHC_ASSERT_NEVER(a_never_busy, busy)
   `RTHC_ASSERT_DELAY(a_latency, take, PIPE_LATENCY, rsp_valid)
   `RTHC_ASSERT_IMPL(a_hue_range, rsp_valid, rsp_hue_sixteenths < 13'd5760)
   `RTHC_ASSERT_IMPL(a_black_sat, rsp_valid && rsp_brightness == '0, rsp_saturation_q16 == '0)
   `RTHC_ASSERT_IMPL(a_black_hue, rsp_valid && rsp_brightness == '0, rsp_hue_sixteenths == '0)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - rgb_to_hsv_converter testbench
// Drives pixels through the converter with random idle gaps or back to back. Each accepted
// transaction is predicted in the testbench and queued. Every strobed result
// is compared field by field with the oldest queued prediction.
// ---------------------------------------------------------------------------

module tb;

   localparam int HUE_SECTOR     = 960;
   localparam int HUE_WRAP       = 5760;
   localparam int RANDOM_PIXELS  = 2000;
   localparam int IDLE_LIMIT     = 500;
   localparam int REPORT_LIMIT   = 10;

   // one predicted hsv triple
   typedef struct {
      logic [12:0] hue;
      logic [16:0] sat;
      logic [7:0]  value;
   } hsv_pixel_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [7:0]  req_red;
   logic [7:0]  req_green;
   logic [7:0]  req_blue;
   logic        rsp_valid;
   logic [12:0] rsp_hue_sixteenths;
   logic [16:0] rsp_saturation_q16;
   logic [7:0]  rsp_brightness;

   hsv_pixel_type pending_hsv[$];
   int          mismatch_count;
   int          idle_cycles;
   bit          back_to_back;

   rgb_to_hsv_converter dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .rsp_valid          (rsp_valid),
      .rsp_hue_sixteenths (rsp_hue_sixteenths),
      .rsp_saturation_q16 (rsp_saturation_q16),
      .rsp_brightness     (rsp_brightness)
   );

   // clock, 8 ns period
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // fixed point hsv of one pixel
   function automatic hsv_pixel_type convert_rgb(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
      hsv_pixel_type       res;
      int                  ri;
      int                  gi;
      int                  bi;
      int                  top;
      int                  bottom;
      int                  delta;
      int                  hue;
      int unsigned         sat;
      rthc_pkg::sector_type sector;
      ri     = r;
      gi     = g;
      bi     = b;
      top    = ri;
      bottom = ri;
      sector = rthc_pkg::SECTOR_RED;
      hue    = 0;
      sat    = 0;
      // ties resolve red first, then green
      if (gi > top) begin
         top    = gi;
         sector = rthc_pkg::SECTOR_GREEN;
      end
      if (bi > top) begin
         top    = bi;
         sector = rthc_pkg::SECTOR_BLUE;
      end
      if (gi < bottom) bottom = gi;
      if (bi < bottom) bottom = bi;
      delta = top - bottom;
      // grey pixels keep hue and saturation at zero
      if (delta != 0) begin
         sat = (delta * 65536) / top;
         case (sector)
            rthc_pkg::SECTOR_RED: begin
               hue = (HUE_SECTOR * (gi - bi)) / delta;
            end
            rthc_pkg::SECTOR_GREEN: begin
               hue = (HUE_SECTOR * (bi - ri)) / delta + int'(rthc_pkg::GREEN_OFFSET);
            end
            default: begin
               hue = (HUE_SECTOR * (ri - gi)) / delta + int'(rthc_pkg::BLUE_OFFSET);
            end
         endcase
         if (hue < 0) hue = hue + HUE_WRAP;
      end
      res.hue   = hue[12:0];
      res.sat   = sat[16:0];
      res.value = top[7:0];
      return res;
   endfunction

   // send one pixel transaction after a random idle gap, or none when back_to_back is set
   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      int gap;
      gap = back_to_back ? 0 : $urandom_range(0, 7);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start     <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      pending_hsv.push_back(convert_rgb(r, g, b));
   endtask

   // result checker
   always @(posedge clock) begin
      hsv_pixel_type want;
      if (!reset && rsp_valid) begin
         if (pending_hsv.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result: hue %0d sat %0d value %0d", rsp_hue_sixteenths,
                        rsp_saturation_q16, rsp_brightness);
         end else begin
            want = pending_hsv.pop_front();
            if (rsp_hue_sixteenths !== want.hue || rsp_saturation_q16 !== want.sat ||
                rsp_brightness !== want.value) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("mismatch: expected hue %0d sat %0d value %0d, got %0d %0d %0d",
                           want.hue, want.sat, want.value, rsp_hue_sixteenths,
                           rsp_saturation_q16, rsp_brightness);
            end
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("** rgb_to_hsv_converter: FAILED **");
         $finish;
      end
   end

   // grey pixels, black and white included
   task automatic test_grey_pixels();
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1, 8'd1, 8'd1);
   endtask

   // red largest, ties with red and negative hue wrap
   task automatic test_red_sector();
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd1);
      send_pixel(8'd200, 8'd100, 8'd50);
   endtask

   // green largest, tie with blue
   task automatic test_green_sector();
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
      send_pixel(8'd10, 8'd255, 8'd200);
      send_pixel(8'd100, 8'd255, 8'd50);
   endtask

   // blue largest on both sides of its sector centre
   task automatic test_blue_sector();
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd200, 8'd0, 8'd255);
      send_pixel(8'd0, 8'd200, 8'd255);
      send_pixel(8'd1, 8'd0, 8'd2);
   endtask

   // saturation of exactly one and of the smallest steps
   task automatic test_saturation_extremes();
      send_pixel(8'd1, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd1, 8'd1, 8'd0);
      send_pixel(8'd254, 8'd255, 8'd255);
   endtask

   // random pixels: uniform, near grey, ties and saturated channels
   task automatic test_random_pixels();
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         if (n % 64 == 0) back_to_back = ($urandom_range(0, 3) == 0);
         r = 8'($urandom);
         g = 8'($urandom);
         b = 8'($urandom);
         case ($urandom_range(0, 4))
            0: begin
               g = 8'(r + $urandom_range(0, 2) - 1);
               b = 8'(r + $urandom_range(0, 2) - 1);
            end
            1: begin
               if ($urandom_range(0, 1)) g = r;
               else b = g;
            end
            2: begin
               r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
               b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
            end
            default: begin
            end
         endcase
         send_pixel(r, g, b);
      end
      back_to_back = 1'b0;
   endtask

   // stimulus sequence
   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_red        = 8'd0;
      req_green      = 8'd0;
      req_blue       = 8'd0;
      mismatch_count = 0;
      idle_cycles    = 0;
      back_to_back   = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_grey_pixels();
      test_red_sector();
      test_green_sector();
      test_blue_sector();
      test_saturation_extremes();
      test_random_pixels();

      @(negedge clock);
      start <= 1'b0;
      // drain, then keep watching for stray results
      while (pending_hsv.size() != 0) @(posedge clock);
      repeat (2 * rthc_pkg::PIPE_LATENCY) @(posedge clock);

      if (mismatch_count == 0 && pending_hsv.size() == 0) begin
         $display("** rgb_to_hsv_converter: PASSED **");
      end else begin
         $display("** rgb_to_hsv_converter: FAILED **");
      end
      $finish;
   end

endmodule
